// ===== rtl/lbmtrt_pkg.sv =====
`timescale 1ns / 1ps

package lbmtrt_pkg;

  // Node geometry.
  localparam int NDIR = 9;
  localparam int NCLS = 5;

  // Port widths.
  localparam int POP_W     = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Internal datapath widths, sized for the full input range.
  localparam int RHO_W   = 28;
  localparam int MOM_W   = 27;
  localparam int EM_W    = 28;
  localparam int SQ_W    = 2 * EM_W;
  localparam int NUM_W   = 60;
  localparam int Q1_SH   = 21;
  localparam int Q1_W    = NUM_W - Q1_SH;
  localparam int QP_W    = Q1_W + CFG_W + 1;
  localparam int FX_SH   = 12;
  localparam int QUAD_W  = QP_W - FX_SH;
  localparam int A_W     = QUAD_W + 1;
  localparam int SYM_W   = 52;
  localparam int ANTI_W  = 34;
  localparam int SPROD_W = SYM_W + CFG_W;
  localparam int APROD_W = ANTI_W + CFG_W;
  localparam int SUM_W   = SPROD_W + 1;
  localparam int DIV_SH  = 15;
  localparam int Z_W     = SUM_W - DIV_SH;
  localparam int ZC_W    = 29;
  localparam int ZOFF_W  = 30;
  localparam int ZS_W    = ZOFF_W + 1;
  localparam int RCP_W   = 30;
  localparam int RCP_SH  = 33;
  localparam int RP_W    = ZOFF_W + RCP_W;
  localparam int QT_W    = RP_W - RCP_SH;
  localparam int VP_W    = MOM_W + CFG_W + 1;
  localparam int SAT_IN_W = VP_W - FX_SH;

  // Rounding offsets and the divide-by-nine constants.
  localparam int RND_Q1    = 1048576;
  localparam int RND_FX    = 2048;
  localparam int RND_DELTA = 147456;
  localparam int ZOFF_BIAS = 301989888;
  localparam int Q_BIAS    = 33554432;
  localparam int RCP_NINE  = 954437176;
  localparam int NINE      = 9;

  // Clamp limits for the scaled collision term; beyond them the output saturates anyway.
  localparam logic signed [Z_W-1:0] ZC_HI = Z_W'(268435455);
  localparam logic signed [Z_W-1:0] ZC_LO = Z_W'(-268435456);

  // Saturation limits of a population.
  localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(8388607);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(-8388608);

  // Register reset values.
  localparam logic signed [CFG_W-1:0] RATE_SYM_RST  = -16'sd2048;
  localparam logic signed [CFG_W-1:0] RATE_ANTI_RST = -16'sd6554;
  localparam logic [CFG_W-1:0]        INV_RHO_RST   = 16'd4096;

  // Direction tables: x and y components, opposite, weight times 72, equilibrium class.
  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int OPP   [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
  localparam int W72   [NDIR] = '{32, 8, 8, 8, 8, 2, 2, 2, 2};
  localparam int QCLS  [NDIR] = '{0, 1, 2, 1, 2, 3, 4, 3, 4};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_SYM  = 2'd0,
    REG_RATE_ANTI = 2'd1,
    REG_INV_RHO   = 2'd2
  } cfg_reg_t;

  typedef logic signed [POP_W-1:0] pop_t;

  // Per-node data that travels alongside the pipeline.
  typedef struct packed {
    logic [NDIR-1:0][POP_W-1:0] f;
    logic signed [RHO_W-1:0]    rho;
    logic signed [MOM_W-1:0]    mx;
    logic signed [MOM_W-1:0]    my;
    logic [POP_W-1:0]           dens;
    logic [POP_W-1:0]           vx;
    logic [POP_W-1:0]           vy;
  } node_t;

  // Clamp a wide signed value to the population range.
  function automatic pop_t sat_pop(input logic signed [SAT_IN_W-1:0] x);
    pop_t r;
    if (x > SAT_HI) begin
      r = SAT_HI[POP_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[POP_W-1:0];
    end else begin
      r = x[POP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/lbm_d2q9_trt_collision.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  pop_rest .. pop_southeast
// output    out        out_valid / out_stall post_* , density, velocity_x, velocity_y
// config    in         cfg_write            cfg_index, cfg_data
//
// One node enters per cycle while in_stall is low; each result passes through the
// eleven register stages: sums, squares, rounding, the two configured scalings,
// and the reciprocal divide by nine.
// Reset clears all valid bits and loads the default rates and 1/rho0.
// A stalled output holds; empty stages still fill, and in_stall rises only
// when all eleven stages hold a node and the output is stalled.
module lbm_d2q9_trt_collision
  import lbmtrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [POP_W-1:0] pop_rest,
  input  logic signed [POP_W-1:0] pop_east,
  input  logic signed [POP_W-1:0] pop_north,
  input  logic signed [POP_W-1:0] pop_west,
  input  logic signed [POP_W-1:0] pop_south,
  input  logic signed [POP_W-1:0] pop_northeast,
  input  logic signed [POP_W-1:0] pop_northwest,
  input  logic signed [POP_W-1:0] pop_southwest,
  input  logic signed [POP_W-1:0] pop_southeast,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [POP_W-1:0] post_rest,
  output logic signed [POP_W-1:0] post_east,
  output logic signed [POP_W-1:0] post_north,
  output logic signed [POP_W-1:0] post_west,
  output logic signed [POP_W-1:0] post_south,
  output logic signed [POP_W-1:0] post_northeast,
  output logic signed [POP_W-1:0] post_northwest,
  output logic signed [POP_W-1:0] post_southwest,
  output logic signed [POP_W-1:0] post_southeast,
  output logic signed [POP_W-1:0] density,
  output logic signed [POP_W-1:0] velocity_x,
  output logic signed [POP_W-1:0] velocity_y,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NSTG = 11;

  // Configuration registers.
  logic signed [CFG_W-1:0] rate_sym;
  logic signed [CFG_W-1:0] rate_anti;
  logic [CFG_W-1:0]        inv_rho;
  logic signed [CFG_W:0]   inv_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_sym  <= RATE_SYM_RST;
      rate_anti <= RATE_ANTI_RST;
      inv_rho   <= INV_RHO_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_RATE_SYM:  rate_sym  <= $signed(cfg_data);
        REG_RATE_ANTI: rate_anti <= $signed(cfg_data);
        REG_INV_RHO:   inv_rho   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign inv_s = $signed({1'b0, inv_rho});

  // Pipeline flow control: a stage advances when it is empty or its successor advances.
  logic [NSTG:1]   vld;
  logic [NSTG+1:1] rdy;

  always_comb begin
    rdy[NSTG+1] = !out_stall;
    for (int i = NSTG; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Side data carried with each node.
  node_t sd [NSTG:1];

  // Stage 1: density and momentum sums.
  pop_t  in_f [NDIR];
  node_t nd_in;

  assign in_f[0] = pop_rest;
  assign in_f[1] = pop_east;
  assign in_f[2] = pop_north;
  assign in_f[3] = pop_west;
  assign in_f[4] = pop_south;
  assign in_f[5] = pop_northeast;
  assign in_f[6] = pop_northwest;
  assign in_f[7] = pop_southwest;
  assign in_f[8] = pop_southeast;

  always_comb begin
    nd_in = '0;
    for (int k = 0; k < NDIR; k++) begin
      nd_in.f[k] = in_f[k];
      nd_in.rho  = nd_in.rho + RHO_W'(in_f[k]);
      if (DIR_X[k] == 1) begin
        nd_in.mx = nd_in.mx + MOM_W'(in_f[k]);
      end else if (DIR_X[k] == -1) begin
        nd_in.mx = nd_in.mx - MOM_W'(in_f[k]);
      end
      if (DIR_Y[k] == 1) begin
        nd_in.my = nd_in.my + MOM_W'(in_f[k]);
      end else if (DIR_Y[k] == -1) begin
        nd_in.my = nd_in.my - MOM_W'(in_f[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sd[1] <= nd_in;
    end
  end

  // Stage 2: the four distinct momentum squares and the velocity products.
  logic signed [EM_W-1:0] dg1, dg2;
  logic signed [SQ_W-1:0] sq_c [4];
  logic signed [SQ_W-1:0] s2_sq [4];
  logic signed [VP_W-1:0] s2_vpx, s2_vpy;
  node_t                  nd2;

  always_comb begin
    dg1 = EM_W'(sd[1].mx) + EM_W'(sd[1].my);
    dg2 = EM_W'(sd[1].mx) - EM_W'(sd[1].my);
    sq_c[0] = SQ_W'(sd[1].mx) * SQ_W'(sd[1].mx);
    sq_c[1] = SQ_W'(sd[1].my) * SQ_W'(sd[1].my);
    sq_c[2] = SQ_W'(dg1) * SQ_W'(dg1);
    sq_c[3] = SQ_W'(dg2) * SQ_W'(dg2);
    nd2      = sd[1];
    nd2.dens = sat_pop(SAT_IN_W'(sd[1].rho));
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_sq  <= sq_c;
      s2_vpx <= VP_W'(sd[1].mx) * VP_W'(inv_s);
      s2_vpy <= VP_W'(sd[1].my) * VP_W'(inv_s);
      sd[2]  <= nd2;
    end
  end

  // Stage 3: quadratic numerators per class, first rounding; velocity rounding.
  logic signed [SQ_W:0]   m2;
  logic signed [SQ_W-1:0] cls_sq [NCLS];
  logic signed [NUM_W-1:0] num_r [NCLS];
  logic signed [Q1_W-1:0] q1_c [NCLS];
  logic signed [Q1_W-1:0] s3_q1 [NCLS];
  logic signed [VP_W-1:0] vrx, vry;
  node_t                  nd3;

  always_comb begin
    m2 = (SQ_W+1)'(s2_sq[0]) + (SQ_W+1)'(s2_sq[1]);
    cls_sq[0] = '0;
    for (int c = 1; c < NCLS; c++) begin
      cls_sq[c] = s2_sq[c-1];
    end
    for (int c = 0; c < NCLS; c++) begin
      num_r[c] = NUM_W'(cls_sq[c]) + (NUM_W'(cls_sq[c]) <<< 3)
               - NUM_W'(m2) - (NUM_W'(m2) <<< 1) + NUM_W'(RND_Q1);
      q1_c[c] = num_r[c][NUM_W-1:Q1_SH];
    end
    vrx = s2_vpx + VP_W'(RND_FX);
    vry = s2_vpy + VP_W'(RND_FX);
    nd3    = sd[2];
    nd3.vx = sat_pop($signed(vrx[VP_W-1:FX_SH]));
    nd3.vy = sat_pop($signed(vry[VP_W-1:FX_SH]));
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_q1 <= q1_c;
      sd[3] <= nd3;
    end
  end

  // Stage 4: scale the quadratic term by 1/rho0.
  logic signed [QP_W-1:0] s4_qp [NCLS];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < NCLS; c++) begin
        s4_qp[c] <= QP_W'(s3_q1[c]) * QP_W'(inv_s);
      end
      sd[4] <= sd[3];
    end
  end

  // Stage 5: second rounding and the scalar part of the equilibrium.
  logic signed [QP_W-1:0] qp_r [NCLS];
  logic signed [A_W-1:0]  a_c [NCLS];
  logic signed [A_W-1:0]  s5_a [NCLS];

  always_comb begin
    for (int c = 0; c < NCLS; c++) begin
      qp_r[c] = s4_qp[c] + QP_W'(RND_FX);
      a_c[c]  = A_W'(sd[4].rho) + A_W'($signed(qp_r[c][QP_W-1:FX_SH]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_a  <= a_c;
      sd[5] <= sd[4];
    end
  end

  // Stage 6: symmetric and antisymmetric non-equilibrium parts, scaled by 72.
  pop_t                     fk [NDIR];
  pop_t                     fo [NDIR];
  logic signed [EM_W-1:0]   em [NDIR];
  logic signed [SYM_W-1:0]  sym_c [NDIR];
  logic signed [ANTI_W-1:0] anti_c [NDIR];
  logic signed [SYM_W-1:0]  s6_sym [NDIR];
  logic signed [ANTI_W-1:0] s6_anti [NDIR];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      fk[k] = $signed(sd[5].f[k]);
      fo[k] = $signed(sd[5].f[OPP[k]]);
      em[k] = '0;
      if (DIR_X[k] == 1) begin
        em[k] = em[k] + EM_W'(sd[5].mx);
      end else if (DIR_X[k] == -1) begin
        em[k] = em[k] - EM_W'(sd[5].mx);
      end
      if (DIR_Y[k] == 1) begin
        em[k] = em[k] + EM_W'(sd[5].my);
      end else if (DIR_Y[k] == -1) begin
        em[k] = em[k] - EM_W'(sd[5].my);
      end
      sym_c[k]  = (SYM_W'(fk[k]) + SYM_W'(fo[k])) * SYM_W'(36)
                - SYM_W'(s5_a[QCLS[k]]) * SYM_W'(W72[k]);
      anti_c[k] = (ANTI_W'(fk[k]) - ANTI_W'(fo[k])) * ANTI_W'(36)
                - ANTI_W'(em[k]) * ANTI_W'(3 * W72[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_sym  <= sym_c;
      s6_anti <= anti_c;
      sd[6]   <= sd[5];
    end
  end

  // Stage 7: apply the two relaxation rates.
  logic signed [SPROD_W-1:0] s7_ps [NDIR];
  logic signed [APROD_W-1:0] s7_pa [NDIR];

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int k = 0; k < NDIR; k++) begin
        s7_ps[k] <= SPROD_W'(s6_sym[k]) * SPROD_W'(rate_sym);
        s7_pa[k] <= APROD_W'(s6_anti[k]) * APROD_W'(rate_anti);
      end
      sd[7] <= sd[6];
    end
  end

  // Stage 8: round, divide by 2^15, clamp and bias for the unsigned divide by nine.
  logic signed [SUM_W-1:0] ysum [NDIR];
  logic signed [Z_W-1:0]   zq [NDIR];
  logic signed [ZC_W-1:0]  zc [NDIR];
  logic signed [ZS_W-1:0]  zs [NDIR];
  logic [ZOFF_W-1:0]       s8_zoff [NDIR];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      ysum[k] = SUM_W'(s7_ps[k]) + SUM_W'(s7_pa[k]) + SUM_W'(RND_DELTA);
      zq[k]   = $signed(ysum[k][SUM_W-1:DIV_SH]);
      if (zq[k] > ZC_HI) begin
        zc[k] = ZC_HI[ZC_W-1:0];
      end else if (zq[k] < ZC_LO) begin
        zc[k] = ZC_LO[ZC_W-1:0];
      end else begin
        zc[k] = zq[k][ZC_W-1:0];
      end
      zs[k] = ZS_W'(zc[k]) + ZS_W'(ZOFF_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int k = 0; k < NDIR; k++) begin
        s8_zoff[k] <= zs[k][ZOFF_W-1:0];
      end
      sd[8] <= sd[7];
    end
  end

  // Stage 9: multiply by the reciprocal of nine.
  logic [RP_W-1:0]   s9_rp [NDIR];
  logic [ZOFF_W-1:0] s9_zoff [NDIR];

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      for (int k = 0; k < NDIR; k++) begin
        s9_rp[k] <= RP_W'(s8_zoff[k]) * RP_W'(RCP_NINE);
      end
      s9_zoff <= s8_zoff;
      sd[9]   <= sd[8];
    end
  end

  // Stage 10: the estimate is low by at most one; fix it with the remainder.
  logic [QT_W-1:0]   q0 [NDIR];
  logic [ZOFF_W-1:0] nine_q [NDIR];
  logic [ZOFF_W-1:0] rem [NDIR];
  logic [QT_W-1:0]   q_c [NDIR];
  logic [QT_W-1:0]   s10_q [NDIR];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      q0[k]     = s9_rp[k][RP_W-1:RCP_SH];
      nine_q[k] = (ZOFF_W'(q0[k]) << 3) + ZOFF_W'(q0[k]);
      rem[k]    = s9_zoff[k] - nine_q[k];
      q_c[k]    = q0[k] + QT_W'(rem[k] >= ZOFF_W'(NINE));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s10_q  <= q_c;
      sd[10] <= sd[9];
    end
  end

  // Stage 11: remove the bias, add to the population and saturate.
  logic signed [SAT_IN_W-1:0] fsum [NDIR];
  pop_t                       post [NDIR];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      fsum[k] = SAT_IN_W'($signed(sd[10].f[k])) + SAT_IN_W'($signed({1'b0, s10_q[k]}))
              - SAT_IN_W'(Q_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      for (int k = 0; k < NDIR; k++) begin
        post[k] <= sat_pop(fsum[k]);
      end
      sd[11] <= sd[10];
    end
  end

  // Output ports.
  assign post_rest      = post[0];
  assign post_east      = post[1];
  assign post_north     = post[2];
  assign post_west      = post[3];
  assign post_south     = post[4];
  assign post_northeast = post[5];
  assign post_northwest = post[6];
  assign post_southwest = post[7];
  assign post_southeast = post[8];
  assign density        = $signed(sd[NSTG].dens);
  assign velocity_x     = $signed(sd[NSTG].vx);
  assign velocity_y     = $signed(sd[NSTG].vy);

endmodule

// ===== rtl/lbmtrt_checker.sv =====
`timescale 1ns / 1ps

module lbmtrt_checker
  import lbmtrt_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [POP_W-1:0] post_rest,
  input logic signed [POP_W-1:0] post_east,
  input logic signed [POP_W-1:0] post_southeast,
  input logic signed [POP_W-1:0] density,
  input logic signed [POP_W-1:0] velocity_x,
  input logic signed [POP_W-1:0] velocity_y
);

  // The input side only stalls when the whole pipeline is full and the output is stalled.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline can still move");

  // Reset empties every stage.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // A stalled result transaction is not dropped.
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

  // A stalled result transaction keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(post_rest) && $stable(post_east)
      && $stable(post_southeast) && $stable(density)
      && $stable(velocity_x) && $stable(velocity_y)))
    else $error("stalled result payload changed");

endmodule

bind lbm_d2q9_trt_collision lbmtrt_checker u_lbmtrt_checker (.*);

// ===== dv/lbm_collision_checker.sv =====
`timescale 1ns / 1ps

// Watches the node and result channels of the TRT collision block, predicts every
// result from the accepted populations and the shadowed registers, and compares.
module lbm_collision_checker
  import lbmtrt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [NDIR-1:0][POP_W-1:0]  pops,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [NDIR+2:0][POP_W-1:0]  results,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  output int                          mismatches,
  output int                          outstanding,
  output int                          results_checked
);

  // Result layout: nine post-collision populations, then density and velocity.
  localparam int DENS_IDX = NDIR;
  localparam int VX_IDX   = NDIR + 1;
  localparam int VY_IDX   = NDIR + 2;
  localparam int MAX_REPORTS = 40;

  typedef logic [NDIR+2:0][POP_W-1:0] node_result_t;

  // Shadow copies of the configuration registers.
  logic signed [CFG_W-1:0] rate_sym;
  logic signed [CFG_W-1:0] rate_anti;
  logic [CFG_W-1:0]        inv_rho;

  node_result_t predicted_nodes[$];
  node_result_t want;

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_checked = 0;
  end

  // Prints one line per mismatch up to a cap, and always counts it.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  function automatic string field_name(input int k);
    case (k)
      0: return "post_rest";
      1: return "post_east";
      2: return "post_north";
      3: return "post_west";
      4: return "post_south";
      5: return "post_northeast";
      6: return "post_northwest";
      7: return "post_southwest";
      8: return "post_southeast";
      DENS_IDX: return "density";
      VX_IDX: return "velocity_x";
      default: return "velocity_y";
    endcase
  endfunction

  // Division by a positive even divisor, rounding half toward plus infinity.
  function automatic longint round_div(input longint x, input longint d);
    longint y;
    longint q;
    y = x + d / 2;
    q = y / d;
    if (y % d != 0 && y < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic logic [POP_W-1:0] clamp_pop(input longint x);
    if (x > 64'sd8388607) begin
      return 24'h7FFFFF;
    end else if (x < -64'sd8388608) begin
      return 24'h800000;
    end
    return x[POP_W-1:0];
  endfunction

  // Moments, incompressible equilibrium and two-rate relaxation of one node.
  function automatic node_result_t collide_node(input logic [NDIR-1:0][POP_W-1:0] p);
    longint f [NDIR];
    longint em [NDIR];
    longint w72 [NDIR];
    int opp [NDIR];
    longint rho, mx, my, m2, quad, a, sym72, anti72, delta, rs, ra, inv;
    node_result_t r;
    rs = longint'(rate_sym);
    ra = longint'(rate_anti);
    inv = longint'(inv_rho);
    rho = 0;
    for (int k = 0; k < NDIR; k++) begin
      f[k] = longint'($signed(p[k]));
      rho = rho + f[k];
    end
    mx = f[1] - f[3] + f[5] - f[6] - f[7] + f[8];
    my = f[2] - f[4] + f[5] + f[6] - f[7] - f[8];
    m2 = mx * mx + my * my;

    // Projection of the momentum on each lattice direction.
    em[0] = 0;        em[1] = mx;       em[2] = my;
    em[3] = -mx;      em[4] = -my;      em[5] = mx + my;
    em[6] = my - mx;  em[7] = -mx - my; em[8] = mx - my;
    opp[0] = 0; opp[1] = 3; opp[2] = 4; opp[3] = 1; opp[4] = 2;
    opp[5] = 7; opp[6] = 8; opp[7] = 5; opp[8] = 6;
    w72[0] = 32;
    for (int k = 1; k < NDIR; k++) begin
      w72[k] = (k < 5) ? 8 : 2;
    end

    for (int k = 0; k < NDIR; k++) begin
      quad = round_div(round_div(9 * em[k] * em[k] - 3 * m2, 64'sd2097152) * inv, 4096);
      a = rho + quad;
      sym72 = 36 * (f[k] + f[opp[k]]) - w72[k] * a;
      anti72 = 36 * (f[k] - f[opp[k]]) - w72[k] * 3 * em[k];
      delta = round_div(rs * sym72 + ra * anti72, 72 * 4096);
      r[k] = clamp_pop(f[k] + delta);
    end
    r[DENS_IDX] = clamp_pop(rho);
    r[VX_IDX] = clamp_pop(round_div(mx * inv, 4096));
    r[VY_IDX] = clamp_pop(round_div(my * inv, 4096));
    return r;
  endfunction

  // Compare result transactions, queue predictions for node transactions,
  // and track register writes.
  always @(posedge clk) begin
    if (rst) begin
      rate_sym = -16'sd2048;
      rate_anti = -16'sd6554;
      inv_rho = 16'd4096;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_nodes.size() == 0) begin
          report_mismatch("result transaction with no node pending");
        end else begin
          want = predicted_nodes.pop_front();
          results_checked++;
          for (int k = 0; k < NDIR + 3; k++) begin
            if (results[k] !== want[k]) begin
              report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                results_checked, field_name(k), $signed(results[k]),
                $signed(want[k])));
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_nodes.push_back(collide_node(pops));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_RATE_SYM: rate_sym = cfg_data;
          REG_RATE_ANTI: rate_anti = cfg_data;
          REG_INV_RHO: inv_rho = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = predicted_nodes.size();
  end

endmodule

// ===== dv/lbm_d2q9_trt_collision_tb.sv =====
`timescale 1ns / 1ps

module lbm_d2q9_trt_collision_tb;
  import lbmtrt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [POP_W-1:0] POP_MAX = 24'h7FFFFF;
  localparam logic [POP_W-1:0] POP_MIN = 24'h800000;
  localparam int W_REST = 466034;
  localparam int W_AXIS = 116508;
  localparam int W_DIAG = 29127;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic [NDIR-1:0][POP_W-1:0] node_pops;
  wire  [NDIR+2:0][POP_W-1:0] node_results;

  int mismatches;
  int outstanding;
  int results_checked;
  int nodes_sent;
  int settings_used;
  int in_gap_max;
  int out_gap_max;

  lbm_d2q9_trt_collision uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pop_rest       (node_pops[0]),
    .pop_east       (node_pops[1]),
    .pop_north      (node_pops[2]),
    .pop_west       (node_pops[3]),
    .pop_south      (node_pops[4]),
    .pop_northeast  (node_pops[5]),
    .pop_northwest  (node_pops[6]),
    .pop_southwest  (node_pops[7]),
    .pop_southeast  (node_pops[8]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .post_rest      (node_results[0]),
    .post_east      (node_results[1]),
    .post_north     (node_results[2]),
    .post_west      (node_results[3]),
    .post_south     (node_results[4]),
    .post_northeast (node_results[5]),
    .post_northwest (node_results[6]),
    .post_southwest (node_results[7]),
    .post_southeast (node_results[8]),
    .density        (node_results[9]),
    .velocity_x     (node_results[10]),
    .velocity_y     (node_results[11]),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  lbm_collision_checker u_collision_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pops            (node_pops),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .results         (node_results),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit well beyond the slowest legal run.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: random stall before each result transaction.
  initial begin : result_stall
    int w;
    out_stall = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      w = $urandom_range(0, out_gap_max);
      if (w != 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Drives one node transaction after a random gap; returns at the falling edge
  // after acceptance.
  task automatic send_node(input logic [NDIR-1:0][POP_W-1:0] v);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    node_pops = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    nodes_sent++;
  endtask

  // Draws a node: near-equilibrium flow, raw bits, field extremes, or
  // same-signed large values that drive the outputs into saturation.
  task automatic make_node(output logic [NDIR-1:0][POP_W-1:0] v);
    int mix;
    int val;
    int base;
    logic neg;
    mix = $urandom_range(0, 99);
    neg = 1'($urandom_range(0, 1));
    for (int k = 0; k < NDIR; k++) begin
      base = (k == 0) ? W_REST : (k < 5) ? W_AXIS : W_DIAG;
      if (mix < 40) begin
        val = base + int'($urandom_range(0, 262143)) - 131072;
      end else if (mix < 70) begin
        val = $urandom;
      end else if (mix < 85) begin
        case ($urandom_range(0, 4))
          0: val = 8388607;
          1: val = -8388608;
          2: val = 0;
          3: val = -1;
          default: val = 1;
        endcase
      end else begin
        val = $urandom_range(4194304, 8388607);
        if (neg) begin
          val = -val - 1;
        end
      end
      v[k] = val[POP_W-1:0];
    end
  endtask

  // Waits until every predicted result has been seen, then lets the pipeline drain.
  task automatic settle();
    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (14) @(negedge clk);
  endtask

  // Writes all registers back to back, with a write to the unused index between.
  task automatic apply_config(input logic [CFG_W-1:0] rs, input logic [CFG_W-1:0] ra,
                              input logic [CFG_W-1:0] inv);
    cfg_write = 1'b1;
    cfg_index = REG_RATE_SYM;
    cfg_data = rs;
    @(negedge clk);
    cfg_index = REG_RATE_ANTI;
    cfg_data = ra;
    @(negedge clk);
    cfg_index = REG_UNUSED;
    cfg_data = CFG_W'($urandom);
    @(negedge clk);
    cfg_index = REG_INV_RHO;
    cfg_data = inv;
    @(negedge clk);
    cfg_write = 1'b0;
    settings_used++;
  endtask

  // Directed nodes: field extremes, lone directions, opposite pairs, rest and flow.
  task automatic run_directed();
    logic [NDIR-1:0][POP_W-1:0] v;
    v = '0;
    send_node(v);
    v = {NDIR{POP_MAX}};
    send_node(v);
    v = {NDIR{POP_MIN}};
    send_node(v);
    v = '1;
    send_node(v);
    for (int k = 0; k < NDIR; k++) begin
      v = '0;
      v[k] = POP_MAX;
      send_node(v);
    end
    v = '0;
    v[1] = POP_MAX;
    v[3] = POP_MIN;
    send_node(v);
    v = '0;
    v[2] = POP_MIN;
    v[4] = POP_MAX;
    send_node(v);
    v = '0;
    v[5] = POP_MAX;
    v[7] = POP_MIN;
    send_node(v);
    for (int k = 0; k < NDIR; k++) begin
      v[k] = k[0] ? POP_MAX : POP_MIN;
    end
    send_node(v);
    // Fluid at rest with unit density, then the same with an eastward drift.
    v[0] = POP_W'(W_REST);
    for (int k = 1; k < NDIR; k++) begin
      v[k] = POP_W'((k < 5) ? W_AXIS : W_DIAG);
    end
    send_node(v);
    v[1] = POP_W'(v[1] + 100000);
    v[5] = POP_W'(v[5] + 30000);
    v[8] = POP_W'(v[8] + 30000);
    send_node(v);
  endtask

  // Random nodes, with the idle limits of both sides redrawn every 50 nodes.
  task automatic run_random(input int count);
    logic [NDIR-1:0][POP_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
        out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      end
      make_node(v);
      send_node(v);
    end
  endtask

  // Main sequence: reset, directed nodes under reset values, then random phases
  // under extreme, identity, default and random register settings.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    node_pops = '0;
    cfg_write = 1'b0;
    cfg_index = REG_RATE_SYM;
    cfg_data = '0;
    in_gap_max = 8;
    out_gap_max = 8;
    nodes_sent = 0;
    settings_used = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    settle();
    apply_config(16'h7FFF, 16'h8000, 16'hFFFF);
    run_random(250);
    settle();
    apply_config(16'h8000, 16'h7FFF, 16'h0000);
    run_random(250);
    settle();
    apply_config(16'h0000, 16'h0000, 16'h1000);
    run_random(250);
    settle();
    apply_config(-16'sd2048, -16'sd6554, 16'd4096);
    run_random(250);
    settle();
    apply_config(CFG_W'(-int'($urandom_range(1, 8191))),
                 CFG_W'(-int'($urandom_range(1, 8191))),
                 CFG_W'($urandom_range(3500, 4700)));
    run_random(250);
    settle();
    apply_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    run_random(250);
    settle();
    apply_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 8192)));
    run_random(250);
    settle();

    $display("Summary: %0d nodes under %0d register settings, %0d results compared.",
             nodes_sent, settings_used, results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
